// ===== rtl/core/tdpt_pkg.sv =====
// tdpt_pkg: shared types and constants of the trial division prime test
// verdict codes and the status word of the remainder unit; no dependencies

package tdpt_pkg;

    typedef enum logic [1:0] {
        VERDICT_COMPOSITE = 2'd0,
        VERDICT_PRIME     = 2'd1,
        VERDICT_NEITHER   = 2'd2
    } verdict_t;

    // first odd trial divisor and the step between odd divisors
    localparam int FIRST_DIVISOR = 3;
    localparam int DIVISOR_STEP  = 2;

    typedef struct packed {
        logic busy;
        logic done;
    } rem_status_t;

endpackage

// ===== rtl/core/trial_division_prime_test.sv =====
// trial_division_prime_test: top level, sequencer over odd trial divisors
// depends on tdpt_pkg and tdpt_rem
//
//  channel | signals                    | payload
//  --------+----------------------------+------------------------
//  input   | in_valid, in_stall         | number [NUMBER_BITS-1:0]
//  output  | out_valid, out_stall       | verdict [1:0]
//
// 0 to 3 and even numbers go from the transfer straight to the finish state.
// other numbers try one odd divisor after another in the bit-serial
// remainder unit; up to about 23000 divisors at 31 bits.
// in_stall is high from the transfer until the verdict is loaded into the
// output register; a held verdict stalls loading of the next one only.
// reset is asynchronous, active low, and leaves the block idle and empty.

module trial_division_prime_test #(
    parameter int NUMBER_BITS = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [NUMBER_BITS-1:0] number,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             verdict
);

    localparam int DW = (NUMBER_BITS + 1) / 2 + 2;
    localparam int SW = NUMBER_BITS + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [NUMBER_BITS-1:0]  n_reg, n_next;
    logic [DW-1:0]           d_reg, d_next;
    logic [SW-1:0]           sq_reg, sq_next;
    tdpt_pkg::verdict_t      res_reg, res_next;
    logic                    out_valid_reg, out_valid_next;
    tdpt_pkg::verdict_t      verdict_reg, verdict_next;
    logic                    rem_start;
    tdpt_pkg::rem_status_t   rem_status;
    logic [DW-1:0]           rem_value;

    tdpt_rem #(
        .DIVIDEND_BITS (NUMBER_BITS),
        .DIVISOR_BITS  (DW)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .status    (rem_status),
        .remainder (rem_value)
    );

    assign rem_start = (state_reg == ST_START);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next  = number;
                    d_next  = DW'(tdpt_pkg::FIRST_DIVISOR);
                    sq_next = SW'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
                    if (number < NUMBER_BITS'(2))
                    begin
                        res_next   = tdpt_pkg::VERDICT_NEITHER;
                        state_next = ST_FINISH;
                    end
                    else if (number < NUMBER_BITS'(4))
                    begin
                        res_next   = tdpt_pkg::VERDICT_PRIME;
                        state_next = ST_FINISH;
                    end
                    else if (!number[0])
                    begin
                        res_next   = tdpt_pkg::VERDICT_COMPOSITE;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > {2'b00, n_reg})
                begin
                    res_next   = tdpt_pkg::VERDICT_PRIME;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_status.done)
                begin
                    if (rem_value == '0)
                    begin
                        res_next   = tdpt_pkg::VERDICT_COMPOSITE;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // (d + 2)^2 = d^2 + 4d + 4
                        sq_next    = sq_reg + SW'({d_reg, 2'b00}) + SW'(4);
                        d_next     = d_reg + DW'(tdpt_pkg::DIVISOR_STEP);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    verdict_next   = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        res_reg     <= res_next;
        verdict_reg <= verdict_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule

// ===== rtl/core/tdpt_rem.sv =====
// tdpt_rem: restoring remainder unit, one quotient bit per cycle
// depends on tdpt_pkg for the status struct

module tdpt_rem #(
    parameter int DIVIDEND_BITS = 31,
    parameter int DIVISOR_BITS  = 18
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIVIDEND_BITS-1:0]  dividend,
    input  logic [DIVISOR_BITS-1:0]   divisor,
    output tdpt_pkg::rem_status_t     status,
    output logic [DIVISOR_BITS-1:0]   remainder
);

    localparam int CW = $clog2(DIVIDEND_BITS + 1);

    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_BITS-1:0] shift_reg, shift_next;
    logic [DIVISOR_BITS-1:0]  div_reg, div_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;

    assign trial = {rem_reg, shift_reg[DIVIDEND_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = '0;
            shift_next = dividend;
            div_next   = divisor;
            cnt_next   = CW'(DIVIDEND_BITS);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the partial remainder below the divisor
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[DIVISOR_BITS-1:0];
            end
            else
            begin
                rem_next = trial[DIVISOR_BITS-1:0];
            end
            shift_next = {shift_reg[DIVIDEND_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        div_reg   <= div_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule
